/* sv/alie_pkg.sv */
// shared constants, codes and types of the array list engine
package alie_pkg;

    // list storage
    localparam int CAPACITY    = 64;
    localparam int MAX_RESULTS = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int DATA_W     = 32;
    localparam int MODE_W     = 3;
    localparam int POS_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 7;

    // width used for index against length compares
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // storage port command from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_cmd_t;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data_out;
        logic [POS_W-1:0]         word_index;
        logic [OUT_CNT_W-1:0]     count_now;
        logic                     last;
    } res_t;

endpackage

/* sv/alie_req_if.sv */
// request channel of the array list engine
interface alie_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [alie_pkg::MODE_W-1:0]            mode;
    logic [alie_pkg::POS_W-1:0]             position;
    logic signed [alie_pkg::DATA_W-1:0]     data_in;

    modport source (output valid, output mode, output position, output data_in,
                    input ready);
    modport sink (input valid, input mode, input position, input data_in,
                  output ready);
endinterface

/* sv/alie_res_if.sv */
// result channel of the array list engine
interface alie_res_if;
    logic                                   valid;
    logic                                   ready;
    logic [alie_pkg::STATUS_W-1:0]          status;
    logic signed [alie_pkg::DATA_W-1:0]     data_out;
    logic [alie_pkg::POS_W-1:0]             word_index;
    logic [alie_pkg::OUT_CNT_W-1:0]         count_now;
    logic                                   last;

    modport source (output valid, output status, output data_out, output word_index,
                    output count_now, output last, input ready);
    modport sink (input valid, input status, input data_out, input word_index,
                  input count_now, input last, output ready);
endinterface

/* sv/alie_ram.sv */
// generic simple dual port ram with registered read
module alie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/alie_ctrl.sv */
// sequencer: decodes requests, walks the store for shifts and dumps
module alie_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    alie_req_if.sink                  req,
    output alie_pkg::ram_cmd_t        ram_cmd,
    input  logic [alie_pkg::DATA_W-1:0] ram_rdata,
    output logic                      res_valid,
    output alie_pkg::res_t            res,
    input  logic                      res_ready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_LAST,
        S_UP_PUT,
        S_DN_RD,
        S_DN_LAST,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMIT
    } state_t;

    state_t                                 state_reg, state_next;
    logic [alie_pkg::CNT_W-1:0]             len_reg, len_next;
    logic [alie_pkg::ADDR_W-1:0]            ptr_reg, ptr_next;
    logic [alie_pkg::ADDR_W-1:0]            pos_reg, pos_next;
    logic [alie_pkg::ADDR_W-1:0]            wdst_reg, wdst_next;
    logic                                   pend_reg, pend_next;
    logic [alie_pkg::DATA_W-1:0]            data_reg, data_next;
    logic [alie_pkg::STATUS_W-1:0]          status_reg, status_next;

    logic [alie_pkg::CMP_W-1:0]             pos_cmp;
    logic [alie_pkg::CMP_W-1:0]             len_cmp;
    logic [alie_pkg::CMP_W-1:0]             ptr_cmp;
    logic [alie_pkg::ADDR_W-1:0]            pos_idx;
    logic [alie_pkg::ADDR_W-1:0]            tail_idx;
    logic                                   full;
    logic                                   pos_bad;
    logic                                   dump_last;

    // index and length compares
    assign pos_cmp   = alie_pkg::CMP_W'(req.position);
    assign len_cmp   = alie_pkg::CMP_W'(len_reg);
    assign ptr_cmp   = alie_pkg::CMP_W'(ptr_reg);
    assign pos_idx   = alie_pkg::ADDR_W'(pos_cmp);
    assign tail_idx  = alie_pkg::ADDR_W'(len_reg - alie_pkg::CNT_W'(1));
    assign full      = (len_reg == alie_pkg::CNT_W'(alie_pkg::CAPACITY));
    assign pos_bad   = (pos_cmp >= len_cmp);
    assign dump_last = (ptr_cmp + alie_pkg::CMP_W'(1) == len_cmp)
                    || (ptr_cmp == alie_pkg::CMP_W'(alie_pkg::MAX_RESULTS - 1));

    assign req.ready = (state_reg == S_IDLE);

    // next state and storage commands
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        wdst_next   = wdst_reg;
        pend_next   = pend_reg;
        data_next   = data_reg;
        status_next = status_reg;

        ram_cmd.we    = 1'b0;
        ram_cmd.waddr = wdst_reg;
        ram_cmd.wdata = ram_rdata;
        ram_cmd.re    = 1'b0;
        ram_cmd.raddr = ptr_reg;

        res_valid      = 1'b0;
        res.status     = status_reg;
        res.data_out   = '0;
        res.word_index = '0;
        res.count_now  = alie_pkg::OUT_CNT_W'(len_reg);
        res.last       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    status_next = alie_pkg::ST_OK;
                    state_next  = S_EMIT;
                    case (req.mode)
                        alie_pkg::MODE_CLEAR:
                        begin
                            len_next = '0;
                        end
                        alie_pkg::MODE_APPEND, alie_pkg::MODE_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = alie_pkg::ST_FULL;
                            end
                            else if (req.mode == alie_pkg::MODE_APPEND || pos_bad)
                            begin
                                ram_cmd.we    = 1'b1;
                                ram_cmd.waddr = alie_pkg::ADDR_W'(len_reg);
                                ram_cmd.wdata = req.data_in;
                                len_next      = len_reg + alie_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                data_next  = req.data_in;
                                pos_next   = pos_idx;
                                ptr_next   = tail_idx;
                                pend_next  = 1'b0;
                                state_next = S_UP_RD;
                            end
                        end
                        alie_pkg::MODE_OVERWRITE:
                        begin
                            if (pos_bad)
                            begin
                                status_next = alie_pkg::ST_BADIDX;
                            end
                            else
                            begin
                                ram_cmd.we    = 1'b1;
                                ram_cmd.waddr = pos_idx;
                                ram_cmd.wdata = req.data_in;
                            end
                        end
                        alie_pkg::MODE_DELETE:
                        begin
                            if (pos_bad)
                            begin
                                status_next = alie_pkg::ST_BADIDX;
                            end
                            else if (pos_cmp + alie_pkg::CMP_W'(1) == len_cmp)
                            begin
                                len_next = len_reg - alie_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                ptr_next   = pos_idx + alie_pkg::ADDR_W'(1);
                                pend_next  = 1'b0;
                                state_next = S_DN_RD;
                            end
                        end
                        alie_pkg::MODE_DUMP:
                        begin
                            if (len_reg == '0)
                            begin
                                status_next = alie_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            status_next = alie_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // insert: move words up, top first, one read and one write a cycle
            S_UP_RD:
            begin
                ram_cmd.re = 1'b1;
                ram_cmd.we = pend_reg;
                wdst_next  = ptr_reg + alie_pkg::ADDR_W'(1);
                pend_next  = 1'b1;
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_UP_LAST;
                end
                else
                begin
                    ptr_next = ptr_reg - alie_pkg::ADDR_W'(1);
                end
            end

            S_UP_LAST:
            begin
                ram_cmd.we = 1'b1;
                state_next = S_UP_PUT;
            end

            S_UP_PUT:
            begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = pos_reg;
                ram_cmd.wdata = data_reg;
                len_next      = len_reg + alie_pkg::CNT_W'(1);
                state_next    = S_EMIT;
            end

            // delete: move words down, bottom first
            S_DN_RD:
            begin
                ram_cmd.re = 1'b1;
                ram_cmd.we = pend_reg;
                wdst_next  = ptr_reg - alie_pkg::ADDR_W'(1);
                pend_next  = 1'b1;
                if (ptr_reg == tail_idx)
                begin
                    state_next = S_DN_LAST;
                end
                else
                begin
                    ptr_next = ptr_reg + alie_pkg::ADDR_W'(1);
                end
            end

            S_DN_LAST:
            begin
                ram_cmd.we = 1'b1;
                len_next   = len_reg - alie_pkg::CNT_W'(1);
                state_next = S_EMIT;
            end

            // dump: read a word, then offer it
            S_DUMP_RD:
            begin
                ram_cmd.re = 1'b1;
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                res_valid      = 1'b1;
                res.status     = alie_pkg::ST_OK;
                res.data_out   = ram_rdata;
                res.word_index = alie_pkg::POS_W'(ptr_reg);
                res.last       = dump_last;
                if (res_ready)
                begin
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + alie_pkg::ADDR_W'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end

            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            pend_reg   <= 1'b0;
            status_reg <= alie_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
        end
    end

    // payload and address registers
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        pos_reg  <= pos_next;
        wdst_reg <= wdst_next;
        data_reg <= data_next;
    end

endmodule

/* sv/array_list_insert_delete_engine.sv */
// top level of the array list engine: sequencer, word store and result register
//
//  port  dir   carries                                       transfer when
//  req   in    mode, position, data_in                       req.valid && req.ready
//  res   out   status, data_out, word_index, count_now, last res.valid && res.ready
//
// one request at a time; clear, append, overwrite and errors finish without a shift
// insert at index p moves the words from the tail down to p up by one, then writes p
// delete at index p moves the words above p down by one; a dump reads and offers each word
// the store has one read and one write port, which pace every shift and dump step
// reset empties the list at once; results wait in an output register under stall
module array_list_insert_delete_engine (
    input  logic       clk,
    input  logic       rst_n,
    alie_req_if.sink   req,
    alie_res_if.source res
);

    alie_pkg::ram_cmd_t              ram_cmd;
    logic [alie_pkg::DATA_W-1:0]     ram_rdata;
    logic                            seq_valid;
    alie_pkg::res_t                  seq_res;
    logic                            seq_ready;
    logic                            out_valid_reg;
    alie_pkg::res_t                  out_reg;

    alie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_cmd   (ram_cmd),
        .ram_rdata (ram_rdata),
        .res_valid (seq_valid),
        .res       (seq_res),
        .res_ready (seq_ready)
    );

    alie_ram #(
        .WIDTH (alie_pkg::DATA_W),
        .DEPTH (alie_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .re    (ram_cmd.re),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata)
    );

    // output register frees the sequencer while a result waits
    assign seq_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_ready)
        begin
            out_valid_reg <= seq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_ready && seq_valid)
        begin
            out_reg <= seq_res;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.status     = out_reg.status;
    assign res.data_out   = out_reg.data_out;
    assign res.word_index = out_reg.word_index;
    assign res.count_now  = out_reg.count_now;
    assign res.last       = out_reg.last;

    // a taken request keeps the block busy in the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while previous one still in progress");

    // the length never exceeds the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.count_now <= alie_pkg::OUT_CNT_W'(alie_pkg::CAPACITY))
        else $error("reported length beyond capacity");

    // only a dump of an empty list reports empty
    a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == alie_pkg::ST_EMPTY |-> res.count_now == '0 && res.last)
        else $error("empty status with nonzero length");

    // a result that is not the last one is a dumped word
    a_mid_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.last |-> res.status == alie_pkg::ST_OK)
        else $error("intermediate result with error status");

endmodule

/* bench/array_list_insert_delete_engine_checker.sv */
// checker of the array list engine: list prediction and result comparison
`timescale 1ns / 100ps
module array_list_insert_delete_engine_checker (
    input  logic clk,
    input  logic rst_n,
    alie_req_if  req,
    alie_res_if  res,
    output int   error_count,
    output int   pending
);

    // words the engine should hold and the results still owed
    logic signed [alie_pkg::DATA_W-1:0] list_words [alie_pkg::CAPACITY];
    int                                 list_count;
    alie_pkg::res_t                     owed_results [$];
    alie_pkg::res_t                     oldest;
    int                                 mismatches = 0;

    assign error_count = mismatches;

    task automatic report_mismatch(input string what,
                                   input logic [alie_pkg::DATA_W-1:0] want,
                                   input logic [alie_pkg::DATA_W-1:0] got);
        mismatches++;
        $display("%0d ns  %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // apply one request to the list and queue the results it owes
    task automatic predict_request(input logic [alie_pkg::MODE_W-1:0] op,
                                   input logic [alie_pkg::POS_W-1:0] idx,
                                   input logic signed [alie_pkg::DATA_W-1:0] word);
        logic [alie_pkg::STATUS_W-1:0] st;
        alie_pkg::res_t                r;
        int                            i;
        int                            n;
        st = alie_pkg::ST_OK;
        r  = '0;
        case (op)
            alie_pkg::MODE_CLEAR: list_count = 0;
            alie_pkg::MODE_APPEND, alie_pkg::MODE_INSERT:
            begin
                if (list_count >= alie_pkg::CAPACITY)
                    st = alie_pkg::ST_FULL;
                else if (op == alie_pkg::MODE_APPEND || idx >= list_count)
                begin
                    // insert past the end lands at the tail
                    list_words[list_count] = word;
                    list_count++;
                end
                else
                begin
                    for (i = list_count; i > idx; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[idx] = word;
                    list_count++;
                end
            end
            alie_pkg::MODE_OVERWRITE:
            begin
                if (idx >= list_count)
                    st = alie_pkg::ST_BADIDX;
                else
                    list_words[idx] = word;
            end
            alie_pkg::MODE_DELETE:
            begin
                if (idx >= list_count)
                    st = alie_pkg::ST_BADIDX;
                else
                begin
                    for (i = idx; i + 1 < list_count; i++)
                        list_words[i] = list_words[i + 1];
                    list_count--;
                end
            end
            alie_pkg::MODE_DUMP:
            begin
                // one word per result, or a single empty marker
                if (list_count == 0)
                begin
                    r.status = alie_pkg::ST_EMPTY;
                    r.last   = 1'b1;
                    owed_results.push_back(r);
                end
                else
                begin
                    n = (list_count > alie_pkg::MAX_RESULTS) ? alie_pkg::MAX_RESULTS
                                                             : list_count;
                    for (i = 0; i < n; i++)
                    begin
                        r.status     = alie_pkg::ST_OK;
                        r.data_out   = list_words[i];
                        r.word_index = i[alie_pkg::POS_W-1:0];
                        r.count_now  = list_count[alie_pkg::OUT_CNT_W-1:0];
                        r.last       = (i == n - 1);
                        owed_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
        if (op != alie_pkg::MODE_DUMP)
        begin
            r.status    = st;
            r.count_now = list_count[alie_pkg::OUT_CNT_W-1:0];
            r.last      = 1'b1;
            owed_results.push_back(r);
        end
    endtask

    // compare result transfers, then predict request transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_count = 0;
            owed_results.delete();
            pending <= 0;
        end
        else
        begin
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("unexpected result, count_now", '0,
                                    alie_pkg::DATA_W'(res.count_now));
                else
                begin
                    oldest = owed_results.pop_front();
                    if (res.status !== oldest.status)
                        report_mismatch("status", alie_pkg::DATA_W'(oldest.status),
                                        alie_pkg::DATA_W'(res.status));
                    if (res.data_out !== oldest.data_out)
                        report_mismatch("data_out", oldest.data_out, res.data_out);
                    if (res.word_index !== oldest.word_index)
                        report_mismatch("word_index", alie_pkg::DATA_W'(oldest.word_index),
                                        alie_pkg::DATA_W'(res.word_index));
                    if (res.count_now !== oldest.count_now)
                        report_mismatch("count_now", alie_pkg::DATA_W'(oldest.count_now),
                                        alie_pkg::DATA_W'(res.count_now));
                    if (res.last !== oldest.last)
                        report_mismatch("last", alie_pkg::DATA_W'(oldest.last),
                                        alie_pkg::DATA_W'(res.last));
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                predict_request(req.mode, req.position, req.data_in);
            pending <= owed_results.size();
        end
    end

endmodule

/* bench/array_list_insert_delete_engine_tb.sv */
// testbench top of the array list engine: stimulus, result sink and verdict
`timescale 1ns / 100ps
module array_list_insert_delete_engine_tb;

    localparam int ITEM_TARGET   = 360;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 200;

    // codes outside the defined operations
    localparam logic [alie_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [alie_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

    // flavors of random episode
    localparam int EP_FILL   = 0;
    localparam int EP_GROW   = 1;
    localparam int EP_SHRINK = 2;
    localparam int EP_CHURN  = 3;

    typedef enum int {
        PICK_APPEND, PICK_INSERT, PICK_PAST_END, PICK_OVERWRITE,
        PICK_DELETE, PICK_NOISE, PICK_DUMP
    } pick_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   list_len = 0;
    int   accepted_items = 0;
    bit   no_gaps = 1'b0;
    int   idle_cycles = 0;
    int   hold_left = 0;
    int   sink_pick;

    alie_req_if req_ch();
    alie_res_if res_ch();

    array_list_insert_delete_engine u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    array_list_insert_delete_engine_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .error_count (mismatches),
        .pending     (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result sink: ready held in stretches, mostly open, some long stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else
        begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 60)
            begin
                res_ch.ready <= 1'b1;
                hold_left    <= $urandom_range(0, 24);
            end
            else if (sink_pick < 90)
            begin
                res_ch.ready <= 1'b0;
                hold_left    <= $urandom_range(0, 2);
            end
            else if (sink_pick < 98)
            begin
                res_ch.ready <= 1'b0;
                hold_left    <= $urandom_range(3, 11);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                hold_left    <= $urandom_range(19, 49);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            || (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int sender_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [alie_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // an index that holds a word, or 0 on an empty list
    function automatic int held_pos();
        if (list_len == 0)
            return 0;
        return $urandom_range(list_len - 1, 0);
    endfunction

    // an index at or past the tail, or 63 on a list of 63 words or more
    function automatic int tail_pos();
        if (list_len >= 63)
            return 63;
        return $urandom_range(63, list_len);
    endfunction

    // one request transfer, after an optional gap
    task automatic send_request(input logic [alie_pkg::MODE_W-1:0] op, input int idx,
                                input logic signed [alie_pkg::DATA_W-1:0] word);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= op;
        req_ch.position <= idx[alie_pkg::POS_W-1:0];
        req_ch.data_in  <= word;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        accepted_items++;
        // track the length only to aim positions
        case (op)
            alie_pkg::MODE_CLEAR:
                list_len = 0;
            alie_pkg::MODE_APPEND, alie_pkg::MODE_INSERT:
                if (list_len < alie_pkg::CAPACITY) list_len++;
            alie_pkg::MODE_DELETE:
                if (idx[alie_pkg::POS_W-1:0] < list_len) list_len--;
            default: ;
        endcase
    endtask

    // hold off the sender until every owed result is in
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // one request drawn from the mix of an episode flavor
    task automatic random_request(input int kind);
        int w [7];
        int r;
        int cat;
        case (kind)
            EP_GROW:   w = '{40, 25, 8, 10, 7, 7, 3};
            EP_SHRINK: w = '{8, 7, 2, 10, 60, 10, 3};
            default:   w = '{18, 18, 6, 18, 25, 12, 3};
        endcase
        r   = $urandom_range(0, 99);
        cat = 0;
        while (r >= w[cat])
        begin
            r -= w[cat];
            cat++;
        end
        case (cat)
            PICK_APPEND:
                send_request(alie_pkg::MODE_APPEND, $urandom_range(0, 63), pick_word());
            PICK_INSERT:
                send_request(alie_pkg::MODE_INSERT, held_pos(), pick_word());
            PICK_PAST_END:
                send_request(alie_pkg::MODE_INSERT, tail_pos(), pick_word());
            PICK_OVERWRITE:
                send_request(alie_pkg::MODE_OVERWRITE, held_pos(), pick_word());
            PICK_DELETE:
                send_request(alie_pkg::MODE_DELETE, held_pos(), pick_word());
            PICK_NOISE:
                send_request(alie_pkg::MODE_W'($urandom_range(0, 7)),
                             $urandom_range(0, 63), pick_word());
            default:
                send_request(alie_pkg::MODE_DUMP, $urandom_range(0, 63), pick_word());
        endcase
    endtask

    // fill to capacity, then knock on the full list and dump it
    task automatic fill_list();
        while (list_len < alie_pkg::CAPACITY)
        begin
            if ($urandom_range(0, 1) == 1)
                send_request(alie_pkg::MODE_APPEND, $urandom_range(0, 63), pick_word());
            else
                send_request(alie_pkg::MODE_INSERT, $urandom_range(0, 63), pick_word());
        end
        send_request(alie_pkg::MODE_APPEND, $urandom_range(0, 63), pick_word());
        send_request(alie_pkg::MODE_INSERT, $urandom_range(0, 63), pick_word());
        send_request(alie_pkg::MODE_DUMP, 0, '0);
    endtask

    // stimulus
    initial
    begin
        int ep;
        int kind;
        int ep_len;
        int i;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= alie_pkg::MODE_CLEAR;
        req_ch.position <= '0;
        req_ch.data_in  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list errors, extremes, shifts at both ends, spare codes
        send_request(alie_pkg::MODE_DUMP, 0, '0);
        send_request(alie_pkg::MODE_DELETE, 0, '0);
        send_request(alie_pkg::MODE_OVERWRITE, 63, 32'h1234_5678);
        send_request(alie_pkg::MODE_APPEND, 0, 32'h7fff_ffff);
        send_request(alie_pkg::MODE_APPEND, 63, 32'h8000_0000);
        send_request(alie_pkg::MODE_INSERT, 0, 32'hffff_ffff);
        send_request(alie_pkg::MODE_INSERT, 63, 32'h0000_0000);
        send_request(alie_pkg::MODE_INSERT, 1, 32'h0000_0005);
        send_request(alie_pkg::MODE_OVERWRITE, 0, 32'h8000_0000);
        send_request(alie_pkg::MODE_OVERWRITE, 4, 32'h7fff_ffff);
        send_request(alie_pkg::MODE_OVERWRITE, 5, 32'h0000_0001);
        send_request(alie_pkg::MODE_DUMP, 0, '0);
        send_request(alie_pkg::MODE_DELETE, 2, '0);
        send_request(alie_pkg::MODE_DELETE, 3, '0);
        send_request(alie_pkg::MODE_DELETE, 0, '0);
        send_request(alie_pkg::MODE_DELETE, 63, '0);
        send_request(MODE_SPARE6, 21, 32'h5555_5555);
        send_request(MODE_SPARE7, 42, 32'haaaa_aaaa);
        send_request(alie_pkg::MODE_DUMP, 0, '0);
        send_request(alie_pkg::MODE_CLEAR, 0, '0);
        send_request(alie_pkg::MODE_DUMP, 0, '0);
        send_request(alie_pkg::MODE_APPEND, 0, 32'h5555_5555);
        send_request(alie_pkg::MODE_APPEND, 0, 32'haaaa_aaaa);
        send_request(alie_pkg::MODE_CLEAR, 63, '0);
        drain_results();

        // random episodes of well-formed traffic with some noise
        ep = 0;
        while (accepted_items < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (ep == 0 || $urandom_range(0, 9) == 0)
                kind = EP_FILL;
            else
                kind = $urandom_range(EP_GROW, EP_CHURN);
            if (kind == EP_FILL)
                fill_list();
            else
            begin
                ep_len = $urandom_range(15, 40);
                for (i = 0; i < ep_len; i++)
                    random_request(kind);
            end
            if ($urandom_range(0, 2) == 0)
                send_request(alie_pkg::MODE_DUMP, $urandom_range(0, 63), pick_word());
            if ($urandom_range(0, 4) == 0)
                drain_results();
            ep++;
        end

        // wind down and give the verdict
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
